// ----- hdl/hcr_pkg.sv -----
package hcr_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int LINE_ROWS     = 4;
  localparam int RESP_W        = 42;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;
  localparam logic [1:0] CFG_K      = 2'd3;

  localparam logic signed [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic win_shift;
    logic acc_clr;
    logic acc_en;
    logic fin1;
    logic fin2;
    logic fin3;
    logic emit;
  } hcr_cmd_t;

  typedef struct packed {
    logic scored;
  } hcr_sts_t;
endpackage

// ----- hdl/hcr_ctrl.sv -----
module hcr_ctrl
  import hcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  hcr_sts_t sts,
  output hcr_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WIN  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_F1   = 7'b0001000,
    S_F2   = 7'b0010000,
    S_F3   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r;
    cmd = '0;
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win_shift = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.scored ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) state_nxt = S_F1;
      end
      S_F1: begin
        cmd.fin1 = 1'b1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.fin2 = 1'b1;
        state_nxt = S_F3;
      end
      S_F3: begin
        cmd.fin3 = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.emit = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ----- hdl/hcr_datapath.sv -----
module hcr_datapath
  import hcr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               in_pixel,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  hcr_cmd_t                 cmd,
  output hcr_sts_t                 sts,
  output logic signed [RESP_W-1:0] out_response,
  output logic [10:0]              out_row,
  output logic [10:0]              out_column,
  output logic signed [RESP_W-1:0] out_frame_max,
  output logic                     out_frame_end
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CAPW = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

  logic [11:0] fw_r, fh_r;
  logic [7:0]  mg_r;
  logic [15:0] k_r;

  logic [7:0] mem0 [MAX_WIDTH];
  logic [7:0] mem1 [MAX_WIDTH];
  logic [7:0] mem2 [MAX_WIDTH];
  logic [7:0] mem3 [MAX_WIDTH];
  logic [7:0] rd_r [4];
  logic [7:0] px_r;

  logic [7:0] win_r [5][5];
  logic [10:0] row_r, col_r;
  logic signed [RESP_W-1:0] max_r;
  logic [10:0] srow_r, scol_r;
  logic send_r, scored_r, wrap_r;
  logic signed [RESP_W-1:0] resp_c, det_r;

  logic [11:0] w, h, m;
  logic [AW-1:0] cidx;
  logic [1:0] slot;

  always_comb begin
    w = (fw_r > 12'(CAPW)) ? 12'(CAPW) : fw_r;
    if (w == 12'd0) w = 12'd1;
    h = (fh_r > 12'd2048) ? 12'd2048 : fh_r;
    if (h == 12'd0) h = 12'd1;
    m = (mg_r < 8'd2) ? 12'd2 : {4'd0, mg_r};
  end

  assign cidx = AW'(col_r);
  assign slot = row_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 12'd1920;
      fh_r <= 12'd1080;
      mg_r <= 8'd51;
      k_r  <= 16'd3277;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  fw_r <= cfg_data[11:0];
        CFG_HEIGHT: fh_r <= cfg_data[11:0];
        CFG_MARGIN: mg_r <= cfg_data[7:0];
        CFG_K:      k_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r[0] <= mem0[cidx];
      rd_r[1] <= mem1[cidx];
      rd_r[2] <= mem2[cidx];
      rd_r[3] <= mem3[cidx];
      px_r <= in_pixel;
      unique case (slot)
        2'd0: mem0[cidx] <= in_pixel;
        2'd1: mem1[cidx] <= in_pixel;
        2'd2: mem2[cidx] <= in_pixel;
        2'd3: mem3[cidx] <= in_pixel;
        default: ;
      endcase
    end
  end

  logic [1:0] slot_d_r;
  logic sc_nxt, wrap_c;
  logic [11:0] r2, c2;
  always_comb begin
    r2 = {1'b0, row_r} - 12'd2;
    c2 = {1'b0, col_r} - 12'd2;
    sc_nxt = (row_r >= 11'd2) && (col_r >= 11'd2) && (r2 >= m) && (r2 < h - m)
             && (c2 >= m) && (c2 < w - m) && (h > m) && (w > m);
    wrap_c = ({1'b0, col_r} + 12'd1 >= w) && ({1'b0, row_r} + 12'd1 >= h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      max_r <= RESP_MIN;
      scored_r <= 1'b0;
      slot_d_r <= '0;
    end else if (cmd.load) begin
      scored_r <= sc_nxt;
      srow_r <= r2[10:0];
      scol_r <= c2[10:0];
      send_r <= (r2 == h - m - 12'd1) && (c2 == w - m - 12'd1);
      wrap_r <= wrap_c;
      slot_d_r <= slot;
      if ({1'b0, col_r} + 12'd1 >= w) begin
        col_r <= '0;
        if ({1'b0, row_r} + 12'd1 >= h) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + 11'd1;
        end
      end else begin
        col_r <= col_r + 11'd1;
      end
    end else if (cmd.emit && wrap_r) begin
      max_r <= RESP_MIN;
    end
    if (!rst_n) begin
    end else if (cmd.fin3 && resp_c > max_r) begin
      max_r <= resp_c;
    end
    if (rst_n && cmd.load && !sc_nxt && wrap_c) max_r <= RESP_MIN;
  end

  assign sts.scored = scored_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          win_r[i][j] <= '0;
    end else if (cmd.win_shift) begin
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 4; j++)
          win_r[i][j] <= win_r[i][j+1];
      for (int i = 0; i < 4; i++)
        win_r[i][4] <= rd_r[2'(slot_d_r + 2'(i))];
      win_r[4][4] <= px_r;
    end
  end

  logic [2:0] ai_row_r, ai_col_r;
  logic signed [20:0] sxx_r, syy_r, sxy_r;
  logic signed [8:0] gx, gy;
  always_comb begin
    gx = $signed({1'b0, win_r[ai_row_r][ai_col_r+3'd1]})
         - $signed({1'b0, win_r[ai_row_r][ai_col_r-3'd1]});
    gy = $signed({1'b0, win_r[ai_row_r+3'd1][ai_col_r]})
         - $signed({1'b0, win_r[ai_row_r-3'd1][ai_col_r]});
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      ai_row_r <= 3'd1;
      ai_col_r <= 3'd1;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (cmd.acc_en) begin
      if (ai_col_r == 3'd3) begin
        ai_col_r <= 3'd1;
        ai_row_r <= ai_row_r + 3'd1;
      end else begin
        ai_col_r <= ai_col_r + 3'd1;
      end
      sxx_r <= sxx_r + 21'(gx * gx);
      syy_r <= syy_r + 21'(gy * gy);
      sxy_r <= sxy_r + 21'(gx * gy);
    end
  end

  logic signed [40:0] p1_r, p2_r;
  logic [40:0] tr2_r;
  logic [20:0] tr;
  logic [56:0] pen_r;
  assign tr = 21'(sxx_r) + 21'(syy_r);
  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      p1_r <= 41'(sxx_r * syy_r);
      p2_r <= 41'(sxy_r * sxy_r);
      tr2_r <= 41'(tr * tr);
    end
    if (cmd.fin2) begin
      det_r <= 42'(p1_r) - 42'(p2_r);
      pen_r <= 57'(tr2_r * k_r);
    end
  end
  assign resp_c = det_r - $signed({1'b0, pen_r[56:16]});

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_response <= resp_c;
      out_frame_max <= (resp_c > max_r) ? resp_c : max_r;
      out_row <= srow_r;
      out_column <= scol_r;
      out_frame_end <= send_r;
    end
  end
endmodule

// ----- hdl/harris_corner_response_core.sv -----
// Each accepted scored pixel gives a result on out_valid; unscored pixels give no result.
// A new pixel is accepted only once the previous one is through, a pace set by the serial
// 3x3 gradient accumulator and the multiply stages for scored pixels; a scored pixel
// waits longer while the previous result is still stalled in the output register.
// Reset (rst_n synchronous, low) restores default registers, clears position,
// window and running maximum; line memory needs no clearing.
module harris_corner_response_core
  import hcr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RESP_W-1:0] out_response,
  output logic [10:0]              out_row,
  output logic [10:0]              out_column,
  output logic signed [RESP_W-1:0] out_frame_max,
  output logic                     out_frame_end,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);
  hcr_cmd_t cmd;
  hcr_sts_t sts;

  assign cfg_ready = 1'b1;

  hcr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  hcr_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .rst_n, .in_pixel, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .cmd, .sts, .out_response, .out_row, .out_column, .out_frame_max, .out_frame_end
  );
endmodule
